FILE: hw/rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SALRU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SALRU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/salru_pkg.sv
`default_nettype none

package salru_pkg;

	localparam int ADDR_W    = 32;
	localparam int TAG_W     = 30;
	localparam int CNT_W     = 32;
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int WAY_OUT_W = 2;
	localparam int OUT_W     = 72;
	localparam int IB_W      = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	localparam logic [CFG_W-1:0] RST_INDEX_BITS  = 3'd7;
	localparam logic [CFG_W-1:0] RST_OFFSET_BITS = 3'd2;
	localparam logic [CFG_W-1:0] RST_WAYS_IN_USE = 3'd1;
	localparam logic [CFG_W-1:0] OB_MIN          = 3'd2;
	localparam logic [CFG_W-1:0] OB_MAX          = 3'd6;

	typedef struct packed {
		logic clr;
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/salru_ctrl.sv
`default_nettype none

module salru_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output salru_pkg::cmd_t      cmd,
	input  wire salru_pkg::sts_t sts
);
	import salru_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_v_q;

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd.clr    = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (!out_v_q || m_tready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;

endmodule

`default_nettype wire

FILE: hw/rtl/salru_dp.sv
`default_nettype none

module salru_dp #(
	parameter int SET_BITS_MAX = 7,
	parameter int WAYS_MAX     = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [salru_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [salru_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic [salru_pkg::ADDR_W-1:0]          address,
	input  wire salru_pkg::cmd_t                       cmd,
	output salru_pkg::sts_t                            sts,
	output logic                                       hit,
	output logic [salru_pkg::WAY_OUT_W-1:0]            way_used,
	output logic [salru_pkg::CNT_W-1:0]                access_count,
	output logic [salru_pkg::CNT_W-1:0]                miss_count
);
	import salru_pkg::*;

	localparam int SETS   = 1 << SET_BITS_MAX;
	localparam int SIDX_W = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
	localparam int WAY_W  = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
	localparam int NW_W   = $clog2(WAYS_MAX + 1);

	// configuration
	logic [CFG_W-1:0] index_bits_q;
	logic [CFG_W-1:0] offset_bits_q;
	logic [CFG_W-1:0] ways_in_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q  <= RST_INDEX_BITS;
			offset_bits_q <= RST_OFFSET_BITS;
			ways_in_use_q <= RST_WAYS_IN_USE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata;
				CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective field widths and associativity
	logic [IB_W-1:0]   ib;
	logic [CFG_W-1:0]  ob;
	logic [NW_W-1:0]   nw;
	logic [4:0]        tag_sh;

	always_comb begin
		if (32'(index_bits_q) > 32'(SET_BITS_MAX)) begin
			ib = IB_W'(SET_BITS_MAX);
		end else begin
			ib = IB_W'(index_bits_q);
		end
		if (offset_bits_q < OB_MIN) begin
			ob = OB_MIN;
		end else if (offset_bits_q > OB_MAX) begin
			ob = OB_MAX;
		end else begin
			ob = offset_bits_q;
		end
		if (ways_in_use_q == '0) begin
			nw = NW_W'(1);
		end else if (32'(ways_in_use_q) > 32'(WAYS_MAX)) begin
			nw = NW_W'(WAYS_MAX);
		end else begin
			nw = NW_W'(ways_in_use_q);
		end
		tag_sh = 5'(ob) + 5'(ib);
	end

	// address split
	logic [ADDR_W-1:0] addr_sh;
	logic [ADDR_W-1:0] set_mask;
	logic [SIDX_W-1:0] set_in;
	logic [TAG_W-1:0]  tag_in;

	assign addr_sh  = address >> ob;
	assign set_mask = (ADDR_W'(1) << ib) - ADDR_W'(1);
	assign set_in   = SIDX_W'(addr_sh & set_mask);
	assign tag_in   = TAG_W'(address >> tag_sh);

	// set rows
	logic [WAYS_MAX-1:0]                  vmem [SETS];
	logic [WAYS_MAX-1:0][WAY_W-1:0]       rmem [SETS];
	logic [WAYS_MAX-1:0][TAG_W-1:0]       tmem [SETS];

	logic [WAYS_MAX-1:0]                  v_s1;
	logic [WAYS_MAX-1:0][WAY_W-1:0]       r_s1;
	logic [WAYS_MAX-1:0][TAG_W-1:0]       t_s1;
	logic [TAG_W-1:0]                     tag_s1;
	logic [SIDX_W-1:0]                    set_s1;

	logic                                 we;
	logic [SIDX_W-1:0]                    wa;
	logic [WAYS_MAX-1:0]                  wv;
	logic [WAYS_MAX-1:0][WAY_W-1:0]       wr;
	logic [WAYS_MAX-1:0][TAG_W-1:0]       wt;

	// clearing pass
	logic [SIDX_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + SIDX_W'(1);
		end
	end

	assign sts.clr_done = cmd.clr && (clr_q == SIDX_W'(SETS - 1));

	// lookup
	logic [WAYS_MAX-1:0]            in_use;
	logic [WAYS_MAX-1:0]            match;
	logic [WAYS_MAX-1:0]            free;
	logic [WAY_W-1:0]               hit_way;
	logic [WAY_W-1:0]               free_way;
	logic [WAY_W-1:0]               victim;
	logic [WAY_W-1:0]               way;
	logic [WAY_W-1:0]               pos;
	logic                           hit_c;
	logic [WAYS_MAX-1:0][WAY_W-1:0] rec_new;
	logic [WAYS_MAX-1:0][WAY_W-1:0] rec_rst;

	always_comb begin
		hit_way  = '0;
		free_way = '0;
		victim   = '0;
		pos      = '0;
		for (int k = 0; k < WAYS_MAX; k++) begin
			in_use[k]  = 32'(k) < 32'(nw);
			match[k]   = in_use[k] && v_s1[k] && (t_s1[k] == tag_s1);
			free[k]    = in_use[k] && !v_s1[k];
			rec_rst[k] = WAY_W'(k);
			if (32'(r_s1[k]) < 32'(nw)) begin
				victim = r_s1[k];
			end
		end
		for (int k = WAYS_MAX - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_way = WAY_W'(k);
			end
			if (free[k]) begin
				free_way = WAY_W'(k);
			end
		end
		hit_c = |match;
		if (hit_c) begin
			way = hit_way;
		end else if (|free) begin
			way = free_way;
		end else begin
			way = victim;
		end
		for (int k = WAYS_MAX - 1; k >= 0; k--) begin
			if (r_s1[k] == way) begin
				pos = WAY_W'(k);
			end
		end
		rec_new = r_s1;
		rec_new[0] = way;
		for (int k = 1; k < WAYS_MAX; k++) begin
			if (32'(k) <= 32'(pos)) begin
				rec_new[k] = r_s1[k-1];
			end
		end
	end

	always_comb begin
		we = cmd.clr || cmd.commit;
		if (cmd.clr) begin
			wa = clr_q;
			wv = '0;
			wr = rec_rst;
			wt = '0;
		end else begin
			wa = set_s1;
			wv = v_s1;
			wr = rec_new;
			wt = t_s1;
			if (!hit_c) begin
				wv[way] = 1'b1;
				wt[way] = tag_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			vmem[wa] <= wv;
			rmem[wa] <= wr;
			tmem[wa] <= wt;
		end
		if (cmd.load) begin
			v_s1   <= vmem[set_in];
			r_s1   <= rmem[set_in];
			t_s1   <= tmem[set_in];
			tag_s1 <= tag_in;
			set_s1 <= set_in;
		end
	end

	// counters and result
	logic [CNT_W-1:0]     acc_q;
	logic [CNT_W-1:0]     miss_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			miss_q <= '0;
		end else if (cmd.commit) begin
			acc_q  <= acc_q + CNT_W'(1);
			miss_q <= miss_q + CNT_W'(!hit_c);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_c;
			way_q <= WAY_OUT_W'(way);
		end
	end

	assign hit          = hit_q;
	assign way_used     = way_q;
	assign access_count = acc_q;
	assign miss_count   = miss_q;

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_lru_tag_lookup.sv
// channel  dir  tdata bits, lowest first
// s_       in   address[31:0]
// m_       out  hit[0], way_used[2:1], access_count[34:3], miss_count[66:35], zero[71:67]
// cfg_     in   cfg_index 0 index_bits, 1 offset_bits, 2 ways_in_use; cfg_wdata[2:0]
//
// two steps per access: the first reads the set row from the tag, valid and recency
// memories, the second compares, picks the way and writes the row back
// after reset a clearing pass over all 2^SET_BITS_MAX sets (128 by default) runs
// before the first transfer is taken; cfg writes are taken during it
// a stalled result holds the compare stage, and no new address is taken
// until that result is registered
`default_nettype none

module set_assoc_lru_tag_lookup #(
	parameter int SET_BITS_MAX = 7,
	parameter int WAYS_MAX     = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [salru_pkg::ADDR_W-1:0]      s_tdata,   // address
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [salru_pkg::OUT_W-1:0]            m_tdata,   // hit, way_used, access_count, miss_count
	input  wire logic                              cfg_we,
	input  wire logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [salru_pkg::CFG_W-1:0]       cfg_wdata
);
	import salru_pkg::*;

	localparam int PAD_W = OUT_W - 1 - WAY_OUT_W - 2 * CNT_W;

	cmd_t                 cmd;
	sts_t                 sts;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way_used;
	logic [CNT_W-1:0]     access_count;
	logic [CNT_W-1:0]     miss_count;

	salru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	salru_dp #(
		.SET_BITS_MAX (SET_BITS_MAX),
		.WAYS_MAX     (WAYS_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.address      (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.hit          (hit),
		.way_used     (way_used),
		.access_count (access_count),
		.miss_count   (miss_count)
	);

	assign m_tdata = {{PAD_W{1'b0}}, miss_count, access_count, way_used, hit};

endmodule

`default_nettype wire

FILE: hw/rtl/salru_chk.sv
`default_nettype none
`include "assert_macros.svh"

module salru_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [salru_pkg::OUT_W-1:0]    m_tdata
);
	import salru_pkg::*;

	`SALRU_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> (!m_tvalid && !s_tready), "ports not quiet in reset")
	`SALRU_ASSERT(a_busy_after_in, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "second address taken while busy")
	`SALRU_ASSERT(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
	`SALRU_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> (m_tdata[OUT_W-1:67] == '0), "result padding not zero")

endmodule

bind set_assoc_lru_tag_lookup salru_chk u_chk (.*);

`default_nettype wire
